>>> sv/c8_pkg.sv
`timescale 1ns / 1ps

package c8_pkg;

  // Memory and display geometry.
  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned MEM_DEPTH = 4096;
  localparam int unsigned DISP_ROWS = 32;
  localparam int unsigned DISP_COLS = 64;
  localparam int unsigned ROW_W     = 5;
  localparam int unsigned COL_W     = 6;

  localparam logic [ADDR_W-1:0] PC_START = 12'h200;
  localparam logic [3:0]        VF_IDX   = 4'hF;

  // Item operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Instruction classes, taken from the top nibble.
  localparam logic [3:0] OPC_CLS = 4'h0;
  localparam logic [3:0] OPC_JP  = 4'h1;
  localparam logic [3:0] OPC_LD  = 4'h6;
  localparam logic [3:0] OPC_ADD = 4'h7;
  localparam logic [3:0] OPC_LDI = 4'hA;
  localparam logic [3:0] OPC_DRW = 4'hD;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data;
  } c8_in_t;

  typedef struct packed {
    logic              pixel;
    logic [ADDR_W-1:0] program_counter;
    logic [7:0]        flag_register;
    logic              status;
  } c8_out_t;

  // Operands of the shared arithmetic unit.
  typedef struct packed {
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic [7:0]        sprite;
    logic [COL_W-1:0]  shift;
  } c8_alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    sum;
    logic [DISP_COLS-1:0] mask;
  } c8_alu_rsp_t;

endpackage

>>> sv/c8_if.sv
`timescale 1ns / 1ps

// Input channel: one command word per handshake.
interface c8_in_if;
  import c8_pkg::*;
  logic   valid;
  logic   ready;
  c8_in_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// Output channel: one status word per handshake.
interface c8_out_if;
  import c8_pkg::*;
  logic    valid;
  logic    ready;
  c8_out_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

>>> sv/chip8_instruction_step_unit.sv
`timescale 1ns / 1ps

// Reduced CHIP-8 core with 4 KiB of program memory, a 64x32 display,
// sixteen 8-bit registers, an index register and a program counter. Each
// input word writes a memory byte, reads a display pixel or executes one
// instruction, and yields one output word with the pixel, the program
// counter, VF and the halted status. The block works on one word at a
// time: it takes no new word until the result of the last one has been
// loaded into the output register. The single program memory port makes
// the fetch read the two instruction bytes one after the other, and
// each sprite row costs a program memory read plus a read-modify-write of
// one display row. The display is kept as 32 rows of 64 bits with a valid
// bit per row, so reset and the clear instruction take effect at once with
// no clearing pass. Memory must be written before it is fetched.
module chip8_instruction_step_unit
  import c8_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  c8_in_if.sink   in_i,
  c8_out_if.source out_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FETCH_HI = 4'd1;
  localparam logic [3:0] S_FETCH_LO = 4'd2;
  localparam logic [3:0] S_DECODE   = 4'd3;
  localparam logic [3:0] S_DRAW_Y   = 4'd4;
  localparam logic [3:0] S_DRAW_RD  = 4'd5;
  localparam logic [3:0] S_DRAW_ROW = 4'd6;
  localparam logic [3:0] S_DRAW_WR  = 4'd7;
  localparam logic [3:0] S_PIXEL    = 4'd8;
  localparam logic [3:0] S_RESP     = 4'd9;

  // Control state.
  logic [3:0]           state_q, state_d;
  logic [ADDR_W-1:0]    pc_q, pc_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  logic                 halted_q, halted_d;
  logic [7:0]           v_q [16];
  logic [7:0]           v_d [16];
  logic [DISP_ROWS-1:0] row_valid_q, row_valid_d;
  logic                 out_valid_q, out_valid_d;

  // Working registers.
  logic [15:0]          instr_q, instr_d;
  logic [7:0]           vx_q, vx_d;
  logic [7:0]           vy_q, vy_d;
  logic [7:0]           sprite_q, sprite_d;
  logic [ROW_W-1:0]     disp_row_q, disp_row_d;
  logic [3:0]           row_cnt_q, row_cnt_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic                 pix_q, pix_d;
  c8_out_t              out_word_q, out_word_d;

  // Memory ports and shared unit.
  logic                 p_we;
  logic [ADDR_W-1:0]    p_addr;
  logic [7:0]           p_rdata;
  logic                 d_we;
  logic [ROW_W-1:0]     d_addr;
  logic [DISP_COLS-1:0] d_wdata;
  logic [DISP_COLS-1:0] d_rdata;
  c8_alu_req_t          alu_req;
  c8_alu_rsp_t          alu_rsp;

  logic                 accept;
  logic [3:0]           rd_idx;
  logic [7:0]           v_rd;
  logic [DISP_COLS-1:0] old_row;
  logic                 collide;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;

  // One register read port: Y while fetching the draw row, X otherwise.
  assign rd_idx = (state_q == S_DRAW_Y) ? instr_q[7:4] : instr_q[11:8];
  assign v_rd   = v_q[rd_idx];

  // Old display row, with rows not written since the last clear as zero.
  assign old_row = row_valid_q[disp_row_q] ? d_rdata : '0;
  assign collide = |(old_row & alu_rsp.mask);

  c8_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .addr_i  (p_addr),
    .wdata_i (in_i.word.data),
    .rdata_o (p_rdata)
  );

  c8_ram #(
    .WIDTH (DISP_COLS),
    .DEPTH (DISP_ROWS)
  ) u_disp_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .addr_i  (d_addr),
    .wdata_i (d_wdata),
    .rdata_o (d_rdata)
  );

  c8_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    idx_d       = idx_q;
    halted_d    = halted_q;
    v_d         = v_q;
    row_valid_d = row_valid_q;
    out_valid_d = out_valid_q;
    instr_d     = instr_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    sprite_d    = sprite_q;
    disp_row_d  = disp_row_q;
    row_cnt_d   = row_cnt_q;
    addr_d      = addr_q;
    pix_d       = pix_q;
    out_word_d  = out_word_q;

    p_we        = 1'b0;
    p_addr      = pc_q;
    d_we        = 1'b0;
    d_addr      = disp_row_q;
    d_wdata     = old_row ^ alu_rsp.mask;

    alu_req.a      = pc_q;
    alu_req.b      = '0;
    alu_req.sprite = sprite_q;
    alu_req.shift  = vx_q[COL_W-1:0];

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          addr_d = in_i.word.address;
          pix_d  = 1'b0;
          priority if (in_i.word.op == OP_WRITE) begin
            p_we    = 1'b1;
            p_addr  = in_i.word.address;
            state_d = S_RESP;
          end else if (in_i.word.op == OP_EXEC && !halted_q) begin
            p_addr  = pc_q;
            state_d = S_FETCH_HI;
          end else if (in_i.word.op == OP_READ && !in_i.word.address[ADDR_W-1]) begin
            d_addr  = in_i.word.address[ROW_W+COL_W-1:COL_W];
            state_d = S_PIXEL;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_FETCH_HI: begin
        instr_d[15:8] = p_rdata;
        alu_req.b     = 12'd1;
        p_addr        = alu_rsp.sum;
        state_d       = S_FETCH_LO;
      end
      S_FETCH_LO: begin
        instr_d[7:0] = p_rdata;
        alu_req.b    = 12'd2;
        pc_d         = alu_rsp.sum;
        state_d      = S_DECODE;
      end
      S_DECODE: begin
        state_d = S_RESP;
        unique case (instr_q[15:12])
          OPC_CLS: row_valid_d = '0;
          OPC_JP:  pc_d = instr_q[11:0];
          OPC_LD:  v_d[instr_q[11:8]] = instr_q[7:0];
          OPC_ADD: begin
            alu_req.a = {4'd0, v_rd};
            alu_req.b = {4'd0, instr_q[7:0]};
            v_d[instr_q[11:8]] = alu_rsp.sum[7:0];
          end
          OPC_LDI: idx_d = instr_q[11:0];
          OPC_DRW: begin
            vx_d    = v_rd;
            state_d = S_DRAW_Y;
          end
          default: halted_d = 1'b1;
        endcase
      end
      S_DRAW_Y: begin
        // Both coordinates are taken before VF is cleared.
        vy_d        = v_rd;
        v_d[VF_IDX] = 8'd0;
        row_cnt_d   = '0;
        state_d     = (instr_q[3:0] == 4'd0) ? S_RESP : S_DRAW_RD;
      end
      S_DRAW_RD: begin
        alu_req.a = idx_q;
        alu_req.b = {8'd0, row_cnt_q};
        p_addr    = alu_rsp.sum;
        state_d   = S_DRAW_ROW;
      end
      S_DRAW_ROW: begin
        sprite_d   = p_rdata;
        alu_req.a  = {4'd0, vy_q};
        alu_req.b  = {8'd0, row_cnt_q};
        d_addr     = alu_rsp.sum[ROW_W-1:0];
        disp_row_d = alu_rsp.sum[ROW_W-1:0];
        state_d    = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        d_we                    = 1'b1;
        row_valid_d[disp_row_q] = 1'b1;
        if (collide) begin
          v_d[VF_IDX] = 8'd1;
        end
        row_cnt_d = row_cnt_q + 4'd1;
        state_d   = (row_cnt_q + 4'd1 == instr_q[3:0]) ? S_RESP : S_DRAW_RD;
      end
      S_PIXEL: begin
        pix_d   = row_valid_q[addr_q[ROW_W+COL_W-1:COL_W]] && d_rdata[addr_q[COL_W-1:0]];
        state_d = S_RESP;
      end
      S_RESP: begin
        // Load the output register once it is free or being emptied.
        if (!out_valid_q || out_o.ready) begin
          out_word_d.pixel           = pix_q;
          out_word_d.program_counter = pc_q;
          out_word_d.flag_register   = v_q[VF_IDX];
          out_word_d.status          = halted_q;
          out_valid_d                = 1'b1;
          state_d                    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Architectural and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= PC_START;
      idx_q       <= '0;
      halted_q    <= 1'b0;
      v_q         <= '{default: 8'd0};
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      halted_q    <= halted_d;
      v_q         <= v_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    instr_q    <= instr_d;
    vx_q       <= vx_d;
    vy_q       <= vy_d;
    sprite_q   <= sprite_d;
    disp_row_q <= disp_row_d;
    row_cnt_q  <= row_cnt_d;
    addr_q     <= addr_d;
    pix_q      <= pix_d;
    out_word_q <= out_word_d;
  end

endmodule

>>> sv/c8_ram.sv
`timescale 1ns / 1ps

// Single-port RAM with registered read data.
module c8_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write when enabled, read the same address every cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> sv/c8_alu.sv
`timescale 1ns / 1ps

// Shared arithmetic unit: a 12-bit adder for addresses, row numbers and
// register adds, and a rotator that places a sprite byte on a display row.
module c8_alu
  import c8_pkg::*;
(
  input  c8_alu_req_t req_i,
  output c8_alu_rsp_t rsp_o
);

  logic [DISP_COLS-1:0]   base;
  logic [2*DISP_COLS-1:0] rot;

  // The leftmost sprite bit lands on the lowest column, so reverse it.
  always_comb begin
    base = '0;
    for (int j = 0; j < 8; j++) begin
      base[j] = req_i.sprite[7-j];
    end
  end

  // Rotate left with wraparound across the row.
  assign rot = {base, base} << req_i.shift;

  assign rsp_o.sum  = req_i.a + req_i.b;
  assign rsp_o.mask = rot[2*DISP_COLS-1:DISP_COLS];

endmodule

>>> sv/c8_checker.sv
`timescale 1ns / 1ps

// Port-level checks of the instruction step unit.
module c8_checker
  import c8_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input c8_out_t out_word_i
);

  logic              halt_seen_q;
  logic [ADDR_W-1:0] last_pc_q;

  // Remember the last delivered program counter and whether a halt was seen.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_seen_q <= 1'b0;
      last_pc_q   <= PC_START;
    end else if (out_valid_i && out_ready_i) begin
      last_pc_q <= out_word_i.program_counter;
      if (out_word_i.status) begin
        halt_seen_q <= 1'b1;
      end
    end
  end

  // A pending word is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // The block takes one word at a time, so ready drops after acceptance.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on consecutive cycles");

  // The halted status is sticky.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && halt_seen_q |-> out_word_i.status)
    else $error("halted status cleared");

  // Once halted, the program counter no longer moves.
  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && halt_seen_q |-> out_word_i.program_counter == last_pc_q)
    else $error("program counter moved while halted");

endmodule

bind chip8_instruction_step_unit c8_checker u_c8_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.word)
);
